>>> hw/rtl/frame_downscale_to_256_unit_macros.svh
// assertion macros for the frame downscale unit
// included by the top level; no other dependencies
`ifndef FRAME_DOWNSCALE_TO_256_UNIT_MACROS_SVH
`define FRAME_DOWNSCALE_TO_256_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define FDS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fds assertion failed");
// next-cycle implication, checked out of reset
`define FDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fds assertion failed");
`else
`define FDS_ASSERT_IMPL(label, ante, cons)
`define FDS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> hw/rtl/fds_pkg.sv
// shared types, constants and codes for the frame downscale unit
// no dependencies
package fds_pkg;

  localparam int OUT_SIDE_DEF    = 256;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int PIX_W   = 32;
  localparam int CHAN_N  = 4;
  localparam int CHAN_W  = 8;
  localparam int PSUM_W  = 9;
  localparam int SUM_W   = CHAN_N * PSUM_W;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_SOURCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TALL_SOURCE = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_word;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] scaled_pixel;
    logic             frame_end;
  } out_t;

  typedef struct packed {
    logic wide_source;
    logic tall_source;
  } cfg_t;

  typedef enum logic [1:0] {
    MODE_DIRECT,
    MODE_ROW_SKIP,
    MODE_PAIR,
    MODE_QUAD
  } mode_t;

  // one classified output pixel on its way to the back end
  typedef struct packed {
    logic             quad;
    logic [SUM_W-1:0] up_sum;
    logic [SUM_W-1:0] cur_sum;
    logic [PIX_W-1:0] word;
    logic             last;
  } job_t;

endpackage

>>> hw/rtl/fds_front.sv
// front end: position counters, pair sums, line store and classification
// depends on fds_pkg
module fds_front #(
  parameter int OUT_SIDE = fds_pkg::OUT_SIDE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  fds_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  fds_pkg::in_t    in_data,
  output logic            push_valid,
  input  logic            push_ready,
  output fds_pkg::job_t   push_job
);

  localparam int CW = $clog2(2 * OUT_SIDE);
  localparam int AW = $clog2(OUT_SIDE);
  localparam logic [CW-1:0] LAST_NARROW = CW'(OUT_SIDE - 1);
  localparam logic [CW-1:0] LAST_WIDE   = CW'(2 * OUT_SIDE - 1);

  logic [CW-1:0]              col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0]              col_cur, row_cur, ocol, orow, last_col, last_row;
  logic [fds_pkg::PIX_W-1:0]  held_r, held_nxt;
  logic [fds_pkg::SUM_W-1:0]  psum, up_r;
  logic [fds_pkg::SUM_W-1:0]  line_mem [OUT_SIDE];
  logic [AW-1:0]              idx;
  logic                       s1_valid_r, s1_valid_nxt;
  fds_pkg::job_t              s1_job_r, job_new;
  fds_pkg::mode_t             mode;
  logic                       accept, emit, mem_we;
  logic [fds_pkg::PIX_W-1:0]  pair_word;

  assign in_ready   = !s1_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = s1_valid_r;

  always_comb begin
    push_job        = s1_job_r;
    push_job.up_sum = up_r;
  end

  assign col_cur  = in_data.frame_start ? '0 : col_r;
  assign row_cur  = in_data.frame_start ? '0 : row_r;
  assign ocol     = cfg.wide_source ? (col_cur >> 1) : col_cur;
  assign orow     = cfg.tall_source ? (row_cur >> 1) : row_cur;
  assign last_col = cfg.wide_source ? LAST_WIDE : LAST_NARROW;
  assign last_row = cfg.tall_source ? LAST_WIDE : LAST_NARROW;
  assign idx      = AW'(col_cur >> 1);

  // per-channel sums of the held even-column pixel and this one
  always_comb begin
    for (int c = 0; c < fds_pkg::CHAN_N; c++) begin
      psum[c*fds_pkg::PSUM_W +: fds_pkg::PSUM_W] =
        {1'b0, held_r[c*fds_pkg::CHAN_W +: fds_pkg::CHAN_W]} +
        {1'b0, in_data.pixel_word[c*fds_pkg::CHAN_W +: fds_pkg::CHAN_W]};
      pair_word[c*fds_pkg::CHAN_W +: fds_pkg::CHAN_W] =
        psum[c*fds_pkg::PSUM_W + 1 +: fds_pkg::CHAN_W];
    end
  end

  always_comb begin
    case ({cfg.wide_source, cfg.tall_source})
      2'b11:   mode = fds_pkg::MODE_QUAD;
      2'b10:   mode = fds_pkg::MODE_PAIR;
      2'b01:   mode = fds_pkg::MODE_ROW_SKIP;
      default: mode = fds_pkg::MODE_DIRECT;
    endcase
  end

  always_comb begin
    emit             = 1'b0;
    mem_we           = 1'b0;
    held_nxt         = held_r;
    job_new.quad     = 1'b0;
    job_new.up_sum   = '0;
    job_new.cur_sum  = psum;
    job_new.word     = in_data.pixel_word;
    job_new.last     = (ocol == CW'(OUT_SIDE - 1)) && (orow == CW'(OUT_SIDE - 1));
    case (mode)
      fds_pkg::MODE_QUAD: begin
        if (!col_cur[0]) begin
          held_nxt = in_data.pixel_word;
        end else if (!row_cur[0]) begin
          mem_we = 1'b1;
        end else begin
          emit         = 1'b1;
          job_new.quad = 1'b1;
        end
      end
      fds_pkg::MODE_PAIR: begin
        if (!col_cur[0]) begin
          held_nxt = in_data.pixel_word;
        end else begin
          emit         = 1'b1;
          job_new.word = pair_word;
        end
      end
      fds_pkg::MODE_ROW_SKIP: begin
        emit = !row_cur[0];
      end
      default: begin
        emit = 1'b1;
      end
    endcase
  end

  always_comb begin
    col_nxt = col_cur + 1'b1;
    row_nxt = row_cur;
    if (col_cur >= last_col) begin
      col_nxt = '0;
      row_nxt = (row_cur >= last_row) ? '0 : row_cur + 1'b1;
    end
  end

  assign s1_valid_nxt = (s1_valid_r && !push_ready) || (accept && emit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      held_r     <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1_job_r <= job_new;
    end
  end

  // line store of even-row pair sums, read into a register loaded along with the front stage job
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      line_mem[idx] <= psum;
    end
    if (accept) begin
      up_r <= line_mem[idx];
    end
  end

endmodule

>>> hw/rtl/fds_queue.sv
// small fifo of classified transactions between front and back end
// depends on fds_pkg
module fds_queue #(
  parameter int DEPTH = fds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  fds_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output fds_pkg::job_t pop_job
);

  localparam int PW   = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  fds_pkg::job_t   slots [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;

  assign push_ready = (cnt_r != CNTW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hw/rtl/fds_back.sv
// back end: finishes the 2x2 average or passes the job word through, and drives the output register
// depends on fds_pkg
module fds_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  fds_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output fds_pkg::out_t out_data
);

  logic                      out_valid_r, out_valid_nxt;
  fds_pkg::out_t             out_data_r;
  logic [fds_pkg::PIX_W-1:0] quad_word;
  logic [fds_pkg::PSUM_W:0]  csum [fds_pkg::CHAN_N];
  logic                      take;

  assign job_ready = !out_valid_r || out_ready;
  assign take      = job_valid && job_ready;

  // add the even-row and odd-row pair sums, keep bits 9..2
  always_comb begin
    for (int c = 0; c < fds_pkg::CHAN_N; c++) begin
      csum[c] = {1'b0, job.up_sum[c*fds_pkg::PSUM_W +: fds_pkg::PSUM_W]} +
                {1'b0, job.cur_sum[c*fds_pkg::PSUM_W +: fds_pkg::PSUM_W]};
      quad_word[c*fds_pkg::CHAN_W +: fds_pkg::CHAN_W] = csum[c][fds_pkg::PSUM_W:2];
    end
  end

  assign out_valid_nxt = take || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.scaled_pixel <= job.quad ? quad_word : job.word;
      out_data_r.frame_end    <= job.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/frame_downscale_to_256_unit.sv
// path: a result passes the front stage job register, a queue slot and the output
// register before out_valid rises; back-pressure can stall it at each of them
// throughput: one source pixel per cycle while the front stage is empty or the queue can
// take its job; the line store reads on every pixel into a register feeding the push job
// reset: synchronous active-low clears size registers, counters, held pixel, queue and
// valid flags; the line store is not cleared and needs no clearing pass
`include "frame_downscale_to_256_unit_macros.svh"
module frame_downscale_to_256_unit #(
  parameter int OUT_SIDE    = fds_pkg::OUT_SIDE_DEF,
  parameter int QUEUE_DEPTH = fds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  fds_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output fds_pkg::out_t                   out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic                            cfg_data
);

  fds_pkg::cfg_t cfg_r, cfg_nxt;
  logic          q_push_valid, q_push_ready, q_pop_valid, q_pop_ready;
  fds_pkg::job_t q_push_job, q_pop_job;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        fds_pkg::REG_WIDE_SOURCE: cfg_nxt.wide_source = cfg_data;
        fds_pkg::REG_TALL_SOURCE: cfg_nxt.tall_source = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fds_front #(
    .OUT_SIDE (OUT_SIDE)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job)
  );

  fds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job)
  );

  fds_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_pop_valid),
    .job_ready (q_pop_ready),
    .job       (q_pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // front stage empty means the input side must be open
  `FDS_ASSERT_IMPL(a_front_open, !q_push_valid, in_ready)
  // a full queue always has something to hand to the back end
  `FDS_ASSERT_IMPL(a_full_has_head, !q_push_ready, q_pop_valid)
  // the back end never overwrites a stalled result
  `FDS_ASSERT_IMPL(a_no_overwrite, q_pop_valid && q_pop_ready, !out_valid || out_ready)
  // a queued transaction that is not taken stays queued
  `FDS_ASSERT_NEXT(a_queue_keeps, q_pop_valid && !q_pop_ready, q_pop_valid)

endmodule

>>> tb/tb_top.sv
// self-checking testbench for frame_downscale_to_256_unit: random and directed pixel
// streams in all four scaling modes, checked against an in-bench downscale predictor
// depends on fds_pkg and the unit's top level
module tb_top;
  import fds_pkg::*;

  localparam int SIDE        = OUT_SIDE_DEF;
  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WIDE_SOURCE;
  logic                 cfg_data = 1'b0;

  // source pixels waiting for the driver, scaled pixels waiting for the block
  in_t  pixel_queue[$];
  out_t expected_pixels[$];
  out_t want;

  // predictor state
  logic             wide_cfg = 1'b0;
  logic             tall_cfg = 1'b0;
  int               col_pos = 0;
  int               row_pos = 0;
  logic [PIX_W-1:0] left_pixel = '0;
  logic [SUM_W-1:0] upper_sums [SIDE];

  logic idle_on = 1'b1;
  int   src_gap = 0;
  int   sink_gap = 0;
  logic hold_arm = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  int cycle_count = 0;
  int fail_count = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int frame_ends = 0;

  frame_downscale_to_256_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    fail_count++;
  endtask

  // advances the source position and queues the scaled pixel this one completes
  function automatic void downscale_pixel(input in_t item);
    int               col;
    int               row;
    int               ocol;
    int               idx;
    logic [SUM_W-1:0] cur_sums;
    logic [PSUM_W:0]  lhs_ch;
    logic [PSUM_W:0]  rhs_ch;
    logic [PSUM_W:0]  quad_ch;
    logic [PIX_W-1:0] word;
    logic             emit;
    out_t             res;
    if (item.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    col = col_pos;
    row = row_pos;
    ocol = col >> wide_cfg;
    idx = ocol % SIDE;
    emit = 1'b0;
    word = item.pixel_word;
    for (int c = 0; c < CHAN_N; c++) begin
      lhs_ch = {2'b00, left_pixel[CHAN_W*c +: CHAN_W]};
      rhs_ch = {2'b00, item.pixel_word[CHAN_W*c +: CHAN_W]};
      cur_sums[PSUM_W*c +: PSUM_W] = PSUM_W'(lhs_ch + rhs_ch);
    end
    if (wide_cfg) begin
      if (col % 2 == 0) begin
        left_pixel = item.pixel_word;
      end else if (tall_cfg && row % 2 == 0) begin
        upper_sums[idx] = cur_sums;
      end else if (tall_cfg) begin
        for (int c = 0; c < CHAN_N; c++) begin
          lhs_ch = {1'b0, upper_sums[idx][PSUM_W*c +: PSUM_W]};
          rhs_ch = {1'b0, cur_sums[PSUM_W*c +: PSUM_W]};
          quad_ch = lhs_ch + rhs_ch;
          word[CHAN_W*c +: CHAN_W] = quad_ch[PSUM_W:2];
        end
        emit = 1'b1;
      end else begin
        for (int c = 0; c < CHAN_N; c++) begin
          word[CHAN_W*c +: CHAN_W] = cur_sums[PSUM_W*c + 1 +: CHAN_W];
        end
        emit = 1'b1;
      end
    end else begin
      emit = !tall_cfg || row % 2 == 0;
    end
    // a position at or past the bound wraps, also right after a size change
    if (col >= (SIDE << wide_cfg) - 1) begin
      col_pos = 0;
      row_pos = (row >= (SIDE << tall_cfg) - 1) ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
    end
    if (emit) begin
      res.scaled_pixel = word;
      res.frame_end = (ocol == SIDE - 1) && ((row >> tall_cfg) == SIDE - 1);
      expected_pixels.push_back(res);
    end
  endfunction

  // source driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        downscale_pixel(in_data);
        pixels_sent <= pixels_sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          in_valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (pixel_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pixel_queue.pop_front();
          if (idle_on && $urandom_range(0, 7) == 0) begin
            src_gap <= $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and backs up its input
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result pixel %h end %b",
                                    out_data.scaled_pixel, out_data.frame_end));
        end else begin
          want = expected_pixels.pop_front();
          results_checked <= results_checked + 1;
          if (want.frame_end) begin
            frame_ends <= frame_ends + 1;
          end
          if (out_data.scaled_pixel !== want.scaled_pixel) begin
            report_mismatch($sformatf("scaled_pixel %h, expected %h",
                                      out_data.scaled_pixel, want.scaled_pixel));
          end
          if (out_data.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, expected %b",
                                      out_data.frame_end, want.frame_end));
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        out_ready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        sink_gap <= $urandom_range(0, 11);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDE_SOURCE) begin
      wide_cfg = val;
    end else begin
      tall_cfg = val;
    end
    @(negedge clk);
  endtask

  task automatic set_mode(input logic wide, input logic tall);
    write_reg(REG_WIDE_SOURCE, wide);
    write_reg(REG_TALL_SOURCE, tall);
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] word, input logic start);
    in_t item;
    item.pixel_word = word;
    item.frame_start = start;
    pixel_queue.push_back(item);
  endtask

  // random pixels, first one optionally restarting the frame; restarts elsewhere per mille
  task automatic queue_pixels(input int count, input logic restart, input int start_permille);
    in_t item;
    for (int k = 0; k < count; k++) begin
      item.pixel_word = $urandom;
      if ($urandom_range(0, 7) == 0) begin
        for (int c = 0; c < CHAN_N; c++) begin
          item.pixel_word[CHAN_W*c +: CHAN_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
      end
      item.frame_start = (k == 0) ? restart : ($urandom_range(0, 999) < start_permille);
      pixel_queue.push_back(item);
    end
  endtask

  // wait for the input side to empty and every scaled pixel to arrive
  task automatic settle();
    @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid) @(negedge clk);
    for (int w = 0; w < DRAIN_LIMIT && expected_pixels.size() != 0; w++) @(negedge clk);
    if (expected_pixels.size() != 0) begin
      report_mismatch($sformatf("%0d expected pixels never arrived", expected_pixels.size()));
      expected_pixels.delete();
    end
    repeat (8) @(negedge clk);
  endtask

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // pass-through at reset sizes, with a restart in mid-frame
    push_pixel(32'h0000_0000, 1'b1);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'h8000_0001, 1'b0);
    push_pixel(32'h7FFF_FFFE, 1'b0);
    push_pixel(32'h1234_5678, 1'b1);
    push_pixel(32'hA5A5_A5A5, 1'b0);
    settle();

    // horizontal pairs: carry into bit 8 and truncation of odd sums
    set_mode(1'b1, 1'b0);
    push_pixel(32'h0000_0000, 1'b1);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'hFFFF_FFFF, 1'b0);
    push_pixel(32'h0101_0101, 1'b0);
    push_pixel(32'h0000_0000, 1'b0);
    push_pixel(32'h00FF_00FF, 1'b0);
    push_pixel(32'hFF00_FF00, 1'b0);
    push_pixel(32'h8080_8080, 1'b1);
    push_pixel(32'h7F7F_7F7F, 1'b0);
    push_pixel(32'h1111_1111, 1'b0);
    settle();

    set_mode(1'b0, 1'b0);
    queue_pixels(40, 1'b0, 20);
    @(posedge clk);
    hold_arm <= 1'b1;
    settle();

    set_mode(1'b1, 1'b0);
    queue_pixels(40, 1'b1, 10);
    settle();

    // 2x2 averaging: the even row starts at full width and ends at normal width, so
    // the odd row comes early and its pairs only read entries written above it
    set_mode(1'b1, 1'b1);
    queue_pixels(32, 1'b1, 0);
    settle();
    set_mode(1'b0, 1'b1);
    queue_pixels(228, 1'b0, 0);
    settle();
    set_mode(1'b1, 1'b1);
    queue_pixels(28, 1'b0, 0);
    settle();

    // back-to-back transactions with no idling on either side
    @(posedge clk);
    idle_on <= 1'b0;
    settle();
    set_mode(1'b0, 1'b0);
    queue_pixels(20, 1'b1, 0);
    settle();
    set_mode(1'b1, 1'b0);
    queue_pixels(20, 1'b1, 0);
    settle();

    $display("summary: %0d source pixels over all four scaling modes, %0d scaled pixels checked",
             pixels_sent, results_checked);
    $display("summary: row wrap, mid-frame restarts and size changes, a long output stall");
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
